@@ rtl/core/eaxa_pkg.sv @@
// ----------------------------------------------------------------------------
// eaxa_pkg
// Shared types, constants and the predictor coefficient table of the
// EA-XA ADPCM decoder.
// ----------------------------------------------------------------------------
package eaxa_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int BLOCK_SAMPLES  = 28;

    // block phase codes
    localparam logic [1:0] PH_CTRL  = 2'd0;
    localparam logic [1:0] PH_SHIFT = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;

    // header byte targets
    localparam logic [1:0] HT_RECENT_L = 2'd0;
    localparam logic [1:0] HT_OLDER_L  = 2'd1;
    localparam logic [1:0] HT_RECENT_R = 2'd2;
    localparam logic [1:0] HT_OLDER_R  = 2'd3;

    localparam logic [4:0] HDR_LEN_MONO   = 5'd4;
    localparam logic [4:0] HDR_LEN_STEREO = 5'd8;

    localparam logic signed [27:0] ROUND_ADD = 28'sh80;
    localparam logic signed [27:0] SAT_MAX   = 28'sh7FFF;
    localparam logic signed [27:0] SAT_MIN   = -28'sh8000;

    // one queued sample computation
    typedef struct packed {
        logic [3:0] nib;
        logic       ch;
        logic [3:0] sel;
        logic [3:0] shift;
        logic       last;
    } t_op;

    function automatic logic signed [9:0] coef(input logic [4:0] idx);
        logic signed [9:0] c;
        unique case (idx)
            5'd1:    c = 10'sd240;
            5'd2:    c = 10'sd460;
            5'd3:    c = 10'sd392;
            5'd6:    c = -10'sd208;
            5'd7:    c = -10'sd220;
            5'd9:    c = 10'sd1;
            5'd10:   c = 10'sd3;
            5'd11:   c = 10'sd4;
            5'd12:   c = 10'sd7;
            5'd13:   c = 10'sd8;
            5'd14:   c = 10'sd10;
            5'd15:   c = 10'sd11;
            5'd17:   c = -10'sd1;
            5'd18:   c = -10'sd3;
            5'd19:   c = -10'sd4;
            default: c = 10'sd0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/ea_xa_adpcm_decoder.sv @@
// ----------------------------------------------------------------------------
// ea_xa_adpcm_decoder
// Byte-serial EA-XA ADPCM chunk decoder, mono or interleaved stereo.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                      payload
//  s_axis   in   i_s_axis_tvalid/o_s_axis_tready tdata {chunk_samples,data_byte}
//                                               tuser chunk_start
//  m_axis   out  o_m_axis_tvalid/i_m_axis_tready tdata sample, tuser channel,
//                                               tlast last
//  cfg      in   i_cfg_valid/o_cfg_ready         i_cfg_data stereo_mode
//
//  A data byte with two samples is worked one sample at a time: the single
//  predictor (two 16x10 multiplies, add, round, clamp) makes one sample per
//  cycle unless the output stalls, since the second mono sample depends on
//  the first. Sequencing state is updated as an item is accepted; one job
//  register holds the pending work. Synchronous active-low reset clears the
//  control, job-valid, history and output-valid state. A stalled output
//  holds a pending sample job, and input ready stays low until it drains.
// ----------------------------------------------------------------------------
module ea_xa_adpcm_decoder #(
    parameter int COUNT_BITS = eaxa_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [7:0] data_byte, [31:8] chunk_samples
    input  logic [0:0]  i_s_axis_tuser,   // [0] chunk_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] sample
    output logic [0:0]  o_m_axis_tuser,   // [0] channel
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_data        // [0] stereo_mode
);

    localparam logic [32:0] CNT_LIM = (33'd1 << COUNT_BITS) - 33'd1;

    // ---------------- control state ----------------
    logic                  r_stereo;
    logic [2:0]            r_hpos,  n_hpos;
    logic                  r_inhdr, n_inhdr;
    logic [1:0]            r_phase, n_phase;
    logic [4:0]            r_bpos,  n_bpos;
    logic [COUNT_BITS-1:0] r_left,  n_left;
    logic [3:0]            r_sel_l, n_sel_l, r_sel_r, n_sel_r;
    logic [3:0]            r_shf_l, n_shf_l, r_shf_r, n_shf_r;

    // ---------------- job register ----------------
    logic                  r_job_v;
    logic                  r_job_hdr, n_job_hdr;
    logic                  r_job_two, n_job_two;
    logic [1:0]            r_job_tgt, n_job_tgt;
    logic                  r_job_hib, n_job_hib;
    logic [7:0]            r_job_byte;
    eaxa_pkg::t_op         r_op0, n_op0, r_op1, n_op1;
    logic                  r_idx;
    logic                  n_job_v;

    // ---------------- predictor history ----------------
    logic [15:0] r_rec_l, r_old_l, r_rec_r, r_old_r;

    // ---------------- output register ----------------
    logic        r_out_v;
    logic [15:0] r_out_s;
    logic        r_out_ch;
    logic        r_out_last;

    logic       s_acc;
    logic       can_out;
    logic       job_done;
    logic [7:0] in_byte;
    logic [3:0] hi_nib, lo_nib;
    logic [2:0] hp_inc;
    logic [4:0] hdr_len;
    logic [4:0] bpos_add;
    logic [32:0] cnt_ext;

    assign in_byte = i_s_axis_tdata[7:0];
    assign hi_nib  = in_byte[7:4];
    assign lo_nib  = in_byte[3:0];
    assign cnt_ext = 33'(i_s_axis_tdata[31:8]);

    assign can_out  = !r_out_v || i_m_axis_tready;
    assign job_done = r_job_v && (r_job_hdr || (can_out && (r_idx == r_job_two)));
    assign o_s_axis_tready = !r_job_v || job_done;
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = 1'b1;

    // accept-time sequencing
    always_comb begin
        n_hpos    = r_hpos;
        n_inhdr   = r_inhdr;
        n_phase   = r_phase;
        n_bpos    = r_bpos;
        n_left    = r_left;
        n_sel_l   = r_sel_l;
        n_sel_r   = r_sel_r;
        n_shf_l   = r_shf_l;
        n_shf_r   = r_shf_r;
        n_job_v   = 1'b0;
        n_job_hdr = 1'b0;
        n_job_two = 1'b0;
        n_job_tgt = r_hpos[2:1];
        n_job_hib = r_hpos[0];
        n_op0     = '0;
        n_op1     = '0;
        hp_inc    = 3'd0;
        hdr_len   = r_stereo ? eaxa_pkg::HDR_LEN_STEREO : eaxa_pkg::HDR_LEN_MONO;
        bpos_add  = 5'd0;

        if (i_s_axis_tuser[0]) begin
            n_left  = COUNT_BITS'((cnt_ext > CNT_LIM) ? CNT_LIM : cnt_ext);
            n_hpos  = 3'd0;
            n_inhdr = 1'b1;
            n_phase = eaxa_pkg::PH_CTRL;
            n_bpos  = 5'd0;
        end

        if (n_inhdr) begin
            n_job_v   = 1'b1;
            n_job_hdr = 1'b1;
            n_job_tgt = n_hpos[2:1];
            n_job_hib = n_hpos[0];
            hp_inc    = n_hpos + 3'd1;
            n_hpos    = hp_inc;
            if ({2'b00, hp_inc} >= hdr_len || hp_inc == 3'd0) begin
                n_inhdr = 1'b0;
                n_hpos  = 3'd0;
            end
        end else if (n_left == '0) begin
            // nothing left in this chunk: byte is dropped
        end else if (n_phase != eaxa_pkg::PH_DATA && n_phase != eaxa_pkg::PH_SHIFT) begin
            n_sel_l = hi_nib;
            if (r_stereo) begin
                n_sel_r = lo_nib;
                n_phase = eaxa_pkg::PH_SHIFT;
            end else begin
                n_shf_l = lo_nib;
                n_phase = eaxa_pkg::PH_DATA;
            end
        end else if (n_phase == eaxa_pkg::PH_SHIFT) begin
            n_shf_l = hi_nib;
            n_shf_r = lo_nib;
            n_phase = eaxa_pkg::PH_DATA;
        end else begin
            n_job_v    = 1'b1;
            n_op0.nib   = hi_nib;
            n_op0.ch    = 1'b0;
            n_op0.sel   = n_sel_l;
            n_op0.shift = n_shf_l;
            if (r_stereo) begin
                n_job_two   = 1'b1;
                n_op0.last  = 1'b0;
                n_op1.nib   = lo_nib;
                n_op1.ch    = 1'b1;
                n_op1.sel   = n_sel_r;
                n_op1.shift = n_shf_r;
                n_op1.last  = (n_left == COUNT_BITS'(1));
                n_left      = n_left - COUNT_BITS'(1);
                bpos_add    = 5'd1;
            end else if (n_left == COUNT_BITS'(1)) begin
                // odd end: low nibble is dropped
                n_op0.last = 1'b1;
                n_left     = '0;
                bpos_add   = 5'd1;
            end else begin
                n_job_two   = 1'b1;
                n_op0.last  = 1'b0;
                n_op1.nib   = lo_nib;
                n_op1.ch    = 1'b0;
                n_op1.sel   = n_sel_l;
                n_op1.shift = n_shf_l;
                n_op1.last  = (n_left == COUNT_BITS'(2));
                n_left      = n_left - COUNT_BITS'(2);
                bpos_add    = 5'd2;
            end
            n_bpos = n_bpos + bpos_add;
            if (n_bpos >= 5'(eaxa_pkg::BLOCK_SAMPLES)) begin
                n_bpos  = 5'd0;
                n_phase = eaxa_pkg::PH_CTRL;
            end
        end
    end

    // ---------------- predictor ----------------
    eaxa_pkg::t_op     cur_op;
    logic signed [15:0] p_rec, p_old;
    logic signed [9:0]  p_c1, p_c2;
    logic signed [3:0]  p_nib;
    logic [4:0]         p_sh;
    logic signed [27:0] p_d;
    logic signed [25:0] p_m1, p_m2;
    logic signed [27:0] p_sum, p_shr;
    logic [15:0]        p_res;

    always_comb begin
        cur_op = r_idx ? r_op1 : r_op0;
        p_rec  = cur_op.ch ? r_rec_r : r_rec_l;
        p_old  = cur_op.ch ? r_old_r : r_old_l;
        p_c1   = eaxa_pkg::coef({1'b0, cur_op.sel});
        p_c2   = eaxa_pkg::coef({1'b0, cur_op.sel} + 5'd4);
        p_nib  = cur_op.nib;
        p_sh   = 5'd20 - {1'b0, cur_op.shift};
        p_d    = 28'(p_nib) <<< p_sh;
        p_m1   = 26'(p_rec) * 26'(p_c1);
        p_m2   = 26'(p_old) * 26'(p_c2);
        p_sum  = p_d + 28'(p_m1) + 28'(p_m2) + eaxa_pkg::ROUND_ADD;
        p_shr  = p_sum >>> 8;
        if (p_shr > eaxa_pkg::SAT_MAX) begin
            p_res = 16'h7FFF;
        end else if (p_shr < eaxa_pkg::SAT_MIN) begin
            p_res = 16'h8000;
        end else begin
            p_res = p_shr[15:0];
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stereo  <= 1'b0;
            r_hpos    <= 3'd0;
            r_inhdr   <= 1'b0;
            r_phase   <= eaxa_pkg::PH_CTRL;
            r_bpos    <= 5'd0;
            r_left    <= '0;
            r_sel_l   <= 4'd0;
            r_sel_r   <= 4'd0;
            r_shf_l   <= 4'd0;
            r_shf_r   <= 4'd0;
            r_job_v   <= 1'b0;
            r_idx     <= 1'b0;
            r_rec_l   <= 16'd0;
            r_old_l   <= 16'd0;
            r_rec_r   <= 16'd0;
            r_old_r   <= 16'd0;
            r_out_v   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_stereo <= i_cfg_data[0];
            end

            if (r_job_v && !r_job_hdr && can_out) begin
                r_out_v <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_v <= 1'b0;
            end

            // job execution
            if (r_job_v && r_job_hdr) begin
                unique case (r_job_tgt)
                    eaxa_pkg::HT_RECENT_L: begin
                        if (r_job_hib) r_rec_l[15:8] <= r_job_byte;
                        else           r_rec_l[7:0]  <= r_job_byte;
                    end
                    eaxa_pkg::HT_OLDER_L: begin
                        if (r_job_hib) r_old_l[15:8] <= r_job_byte;
                        else           r_old_l[7:0]  <= r_job_byte;
                    end
                    eaxa_pkg::HT_RECENT_R: begin
                        if (r_job_hib) r_rec_r[15:8] <= r_job_byte;
                        else           r_rec_r[7:0]  <= r_job_byte;
                    end
                    eaxa_pkg::HT_OLDER_R: begin
                        if (r_job_hib) r_old_r[15:8] <= r_job_byte;
                        else           r_old_r[7:0]  <= r_job_byte;
                    end
                    default: ;
                endcase
            end else if (r_job_v && can_out) begin
                r_out_s    <= p_res;
                r_out_ch   <= cur_op.ch;
                r_out_last <= cur_op.last;
                if (cur_op.ch) begin
                    r_old_r <= r_rec_r;
                    r_rec_r <= p_res;
                end else begin
                    r_old_l <= r_rec_l;
                    r_rec_l <= p_res;
                end
                // back to the first sample once the job is done
                r_idx <= !job_done;
            end

            if (s_acc) begin
                r_job_v <= n_job_v;
            end else if (job_done) begin
                r_job_v <= 1'b0;
            end

            if (s_acc) begin
                r_hpos  <= n_hpos;
                r_inhdr <= n_inhdr;
                r_phase <= n_phase;
                r_bpos  <= n_bpos;
                r_left  <= n_left;
                r_sel_l <= n_sel_l;
                r_sel_r <= n_sel_r;
                r_shf_l <= n_shf_l;
                r_shf_r <= n_shf_r;
            end
        end
    end

    // job payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_job_hdr  <= n_job_hdr;
            r_job_two  <= n_job_two;
            r_job_tgt  <= n_job_tgt;
            r_job_hib  <= n_job_hib;
            r_job_byte <= in_byte;
            r_op0      <= n_op0;
            r_op1      <= n_op1;
        end
    end

    assign o_m_axis_tvalid   = r_out_v;
    assign o_m_axis_tdata    = r_out_s;
    assign o_m_axis_tuser[0] = r_out_ch;
    assign o_m_axis_tlast    = r_out_last;

endmodule
